/* design/jksd_pkg.sv */
// Package for the JSON key and string decoder.
// Holds the decoder state and result types, character constants and helper functions.
// No dependencies.
package jksd_pkg;

    localparam int CHAR_W = 21;
    localparam int HEX_W  = 16;
    localparam int CNT_W  = 3;

    localparam logic [CNT_W-1:0] HEX_IDLE = 3'd4;

    localparam logic [CHAR_W-1:0] CH_DQUOTE    = 21'h22;
    localparam logic [CHAR_W-1:0] CH_SQUOTE    = 21'h27;
    localparam logic [CHAR_W-1:0] CH_BACKSLASH = 21'h5C;
    localparam logic [CHAR_W-1:0] CH_SLASH     = 21'h2F;
    localparam logic [CHAR_W-1:0] CH_LOWER_B   = 21'h62;
    localparam logic [CHAR_W-1:0] CH_LOWER_T   = 21'h74;
    localparam logic [CHAR_W-1:0] CH_LOWER_N   = 21'h6E;
    localparam logic [CHAR_W-1:0] CH_LOWER_R   = 21'h72;
    localparam logic [CHAR_W-1:0] CH_LOWER_F   = 21'h66;
    localparam logic [CHAR_W-1:0] CH_LOWER_U   = 21'h75;
    localparam logic [CHAR_W-1:0] CH_TAB       = 21'h09;
    localparam logic [CHAR_W-1:0] CH_LF        = 21'h0A;
    localparam logic [CHAR_W-1:0] CH_CR        = 21'h0D;
    localparam logic [CHAR_W-1:0] CH_FF        = 21'h0C;
    localparam logic [CHAR_W-1:0] CH_BS        = 21'h08;
    localparam logic [CHAR_W-1:0] CH_SPACE     = 21'h20;
    localparam logic [CHAR_W-1:0] CH_COMMA     = 21'h2C;
    localparam logic [CHAR_W-1:0] CH_COLON     = 21'h3A;

    typedef enum logic [1:0] {
        MODE_WAIT   = 2'd0,
        MODE_QUOTED = 2'd1,
        MODE_BARE   = 2'd2
    } mode_t;

    typedef struct packed {
        mode_t              mode;
        logic               single_quoted;
        logic               in_escape;
        logic [CNT_W-1:0]   hex_count;
        logic [HEX_W-1:0]   hex_value;
    } state_t;

    typedef struct packed {
        logic               out_valid;
        logic [CHAR_W-1:0]  out_char;
        logic               finished;
        logic               failed;
        logic               pushed_back;
    } result_t;

    localparam state_t STATE_RESET = '{
        mode:          MODE_WAIT,
        single_quoted: 1'b0,
        in_escape:     1'b0,
        hex_count:     HEX_IDLE,
        hex_value:     '0
    };

    // Returns {valid, value} for one hex digit.
    function automatic logic [4:0] hex_digit(input logic [CHAR_W-1:0] c);
        logic [4:0] r;
        r = 5'd0;
        if (c >= 21'h30 && c <= 21'h39) begin
            r = {1'b1, 4'(c - 21'h30)};
        end
        else if (c >= 21'h61 && c <= 21'h66) begin
            r = {1'b1, 4'(c - 21'h57)};
        end
        else if (c >= 21'h41 && c <= 21'h46) begin
            r = {1'b1, 4'(c - 21'h37)};
        end
        return r;
    endfunction

    // Returns {valid, character} for the single-character escapes.
    function automatic logic [CHAR_W:0] escape_char(input logic [CHAR_W-1:0] c);
        logic [CHAR_W:0] r;
        r = '0;
        unique case (c)
            CH_BACKSLASH: r = {1'b1, CH_BACKSLASH};
            CH_DQUOTE:    r = {1'b1, CH_DQUOTE};
            CH_SLASH:     r = {1'b1, CH_SLASH};
            CH_LOWER_B:   r = {1'b1, CH_BS};
            CH_LOWER_T:   r = {1'b1, CH_TAB};
            CH_LOWER_N:   r = {1'b1, CH_LF};
            CH_LOWER_R:   r = {1'b1, CH_CR};
            CH_LOWER_F:   r = {1'b1, CH_FF};
            default:      r = '0;
        endcase
        return r;
    endfunction

endpackage

/* design/jksd_decode.sv */
// Combinational decode step: next state and result for one input item.
// Depends on jksd_pkg.
module jksd_decode (
    input  jksd_pkg::state_t                 state,
    input  logic [jksd_pkg::CHAR_W-1:0]      ch,
    input  logic                             end_of_input,
    output jksd_pkg::state_t                 state_next,
    output jksd_pkg::result_t                result
);

    logic [jksd_pkg::CHAR_W-1:0] quote;
    logic                        quote_hit;
    logic                        is_backslash;
    logic                        is_u;
    logic [jksd_pkg::CHAR_W:0]   esc;
    logic [4:0]                  hex;
    logic [jksd_pkg::HEX_W-1:0]  hex_acc;
    logic [jksd_pkg::CNT_W-1:0]  hex_cnt_inc;
    logic                        in_hex;
    logic                        is_term;
    logic                        is_first_quote;

    assign quote        = state.single_quoted ? jksd_pkg::CH_SQUOTE : jksd_pkg::CH_DQUOTE;
    assign quote_hit    = (ch == quote);
    assign is_backslash = (ch == jksd_pkg::CH_BACKSLASH);
    assign is_u         = (ch == jksd_pkg::CH_LOWER_U);
    assign esc          = jksd_pkg::escape_char(ch);
    assign hex          = jksd_pkg::hex_digit(ch);
    assign hex_acc      = {state.hex_value[jksd_pkg::HEX_W-5:0], hex[3:0]};
    assign hex_cnt_inc  = jksd_pkg::CNT_W'(state.hex_count + 3'd1);
    assign in_hex       = (state.hex_count < jksd_pkg::HEX_IDLE);
    assign is_term      = (ch == jksd_pkg::CH_LF) || (ch == jksd_pkg::CH_CR) ||
                          (ch == jksd_pkg::CH_TAB) || (ch == jksd_pkg::CH_SPACE) ||
                          (ch == jksd_pkg::CH_COMMA) || (ch == jksd_pkg::CH_COLON);
    assign is_first_quote = (ch == jksd_pkg::CH_DQUOTE) || (ch == jksd_pkg::CH_SQUOTE);

    always_comb
    begin
        state_next = state;
        unique case (state.mode)
            jksd_pkg::MODE_QUOTED:
            begin
                if (end_of_input) begin
                    state_next = jksd_pkg::STATE_RESET;
                end
                else if (state.in_escape) begin
                    state_next.in_escape = 1'b0;
                    if (esc[jksd_pkg::CHAR_W]) begin
                        state_next.in_escape = 1'b0;
                    end
                    else if (is_u) begin
                        state_next.hex_value = '0;
                        state_next.hex_count = '0;
                    end
                    else begin
                        state_next = jksd_pkg::STATE_RESET;
                    end
                end
                else if (quote_hit) begin
                    state_next = jksd_pkg::STATE_RESET;
                end
                else if (is_backslash) begin
                    state_next.in_escape = 1'b1;
                end
                else if (in_hex) begin
                    if (!hex[4]) begin
                        state_next = jksd_pkg::STATE_RESET;
                    end
                    else begin
                        state_next.hex_value = hex_acc;
                        state_next.hex_count = hex_cnt_inc;
                    end
                end
            end
            jksd_pkg::MODE_BARE:
            begin
                if (end_of_input || is_term) begin
                    state_next = jksd_pkg::STATE_RESET;
                end
            end
            default:
            begin
                state_next = jksd_pkg::STATE_RESET;
                if (!end_of_input) begin
                    if (is_first_quote) begin
                        state_next.mode          = jksd_pkg::MODE_QUOTED;
                        state_next.single_quoted = (ch == jksd_pkg::CH_SQUOTE);
                    end
                    else begin
                        state_next.mode = jksd_pkg::MODE_BARE;
                    end
                end
            end
        endcase
    end

    always_comb
    begin
        result = '0;
        unique case (state.mode)
            jksd_pkg::MODE_QUOTED:
            begin
                if (end_of_input) begin
                    result.failed = 1'b1;
                end
                else if (state.in_escape) begin
                    if (esc[jksd_pkg::CHAR_W]) begin
                        result.out_valid = 1'b1;
                        result.out_char  = esc[jksd_pkg::CHAR_W-1:0];
                    end
                    else if (!is_u) begin
                        result.failed = 1'b1;
                    end
                end
                else if (quote_hit) begin
                    result.finished = 1'b1;
                end
                else if (is_backslash) begin
                    result.out_valid = 1'b0;
                end
                else if (in_hex) begin
                    if (!hex[4]) begin
                        result.failed = 1'b1;
                    end
                    else if (hex_cnt_inc == jksd_pkg::HEX_IDLE) begin
                        result.out_valid = 1'b1;
                        result.out_char  = jksd_pkg::CHAR_W'(hex_acc);
                    end
                end
                else begin
                    result.out_valid = 1'b1;
                    result.out_char  = ch;
                end
            end
            jksd_pkg::MODE_BARE:
            begin
                if (end_of_input) begin
                    result.finished = 1'b1;
                end
                else if (is_term) begin
                    result.finished    = 1'b1;
                    result.pushed_back = 1'b1;
                end
                else begin
                    result.out_valid = 1'b1;
                    result.out_char  = ch;
                end
            end
            default:
            begin
                if (end_of_input) begin
                    result.failed = 1'b1;
                end
                else if (!is_first_quote) begin
                    result.out_valid = 1'b1;
                    result.out_char  = ch;
                end
            end
        endcase
    end

endmodule

/* design/json_key_string_decoder.sv */
// Top level of the JSON key and string decoder: stream ports, state and result registers.
// Depends on jksd_pkg and jksd_decode.
//
//  Channel   Direction  Payload
//  s_axis    in         tdata: ch; tlast: end_of_input
//  m_axis    out        tdata: out_char; tlast: finished; tuser: out_valid, failed, pushed_back
//
// Every accepted item gives exactly one result item, registered and presented in the cycle after acceptance.
// An item can be accepted every cycle while the output is not stalled; the decode state updates at acceptance.
// The result register takes a new item whenever it is empty or being drained.
// A stall on the output holds the input back only while the result register is full.
// Reset returns the decoder to waiting for the first character of a token.
module json_key_string_decoder (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [23:0] s_axis_tdata,   // [20:0] ch, [23:21] zero
    input  logic        s_axis_tlast,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata,   // [20:0] out_char, [23:21] zero
    output logic        m_axis_tlast,
    output logic [2:0]  m_axis_tuser    // [0] out_valid, [1] failed, [2] pushed_back
);

    jksd_pkg::state_t  state_reg;
    jksd_pkg::state_t  state_next;
    jksd_pkg::result_t result_reg;
    jksd_pkg::result_t result_next;
    logic              m_valid_reg;
    logic              accept;

    assign s_axis_tready = !m_valid_reg || m_axis_tready;
    assign accept        = s_axis_tvalid && s_axis_tready;

    jksd_decode u_decode (
        .state        (state_reg),
        .ch           (s_axis_tdata[jksd_pkg::CHAR_W-1:0]),
        .end_of_input (s_axis_tlast),
        .state_next   (state_next),
        .result       (result_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            state_reg   <= jksd_pkg::STATE_RESET;
            m_valid_reg <= 1'b0;
        end
        else begin
            if (accept) begin
                state_reg <= state_next;
            end
            if (accept) begin
                m_valid_reg <= 1'b1;
            end
            else if (m_axis_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept) begin
            result_reg <= result_next;
        end
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = {3'b000, result_reg.out_char};
    assign m_axis_tlast  = result_reg.finished;
    assign m_axis_tuser  = {result_reg.pushed_back, result_reg.failed, result_reg.out_valid};

endmodule

/* verif/json_key_string_decoder_test.sv */
`timescale 1ns / 1ps
// Self-checking testbench for json_key_string_decoder: directed and random character streams,
// predicted item by item and compared with every result item. Depends on jksd_pkg and the RTL.
module json_key_string_decoder_test;

    localparam int ITEM_TARGET    = 1850;
    localparam int WATCHDOG_LIMIT = 3000;
    localparam int HOLD_CYCLES    = 300;
    localparam int DRAIN_CYCLES   = 10;

    localparam logic [jksd_pkg::CHAR_W-1:0] DIGIT_0 = 21'h30;
    localparam logic [jksd_pkg::CHAR_W-1:0] UPPER_A = 21'h41;
    localparam logic [jksd_pkg::CHAR_W-1:0] LOWER_A = 21'h61;
    localparam logic [jksd_pkg::CHAR_W-1:0] LOWER_G = 21'h67;
    localparam logic [jksd_pkg::CHAR_W-1:0] LOWER_X = 21'h78;
    localparam logic [jksd_pkg::CHAR_W-1:0] MAX_CP  = 21'h10FFFF;

    localparam logic [jksd_pkg::CHAR_W-1:0] ESCAPES [8] = '{jksd_pkg::CH_BACKSLASH,
        jksd_pkg::CH_DQUOTE, jksd_pkg::CH_SLASH, jksd_pkg::CH_LOWER_B, jksd_pkg::CH_LOWER_T,
        jksd_pkg::CH_LOWER_N, jksd_pkg::CH_LOWER_R, jksd_pkg::CH_LOWER_F};
    localparam logic [jksd_pkg::CHAR_W-1:0] SYMBOL_ENDS [6] = '{jksd_pkg::CH_SPACE,
        jksd_pkg::CH_TAB, jksd_pkg::CH_CR, jksd_pkg::CH_LF, jksd_pkg::CH_COMMA,
        jksd_pkg::CH_COLON};

    class decoder_scoreboard;
        jksd_pkg::mode_t            mode;
        logic                       single_quoted;
        logic                       in_escape;
        logic [jksd_pkg::CNT_W-1:0] hex_count;
        logic [jksd_pkg::HEX_W-1:0] hex_value;
        jksd_pkg::result_t          pending_results[$];
        int                         errors;

        function new();
            clear_token();
            errors = 0;
        endfunction

        function void clear_token();
            mode = jksd_pkg::MODE_WAIT;
            single_quoted = 1'b0;
            in_escape = 1'b0;
            hex_count = jksd_pkg::HEX_IDLE;
            hex_value = '0;
        endfunction

        function bit ends_symbol(logic [jksd_pkg::CHAR_W-1:0] c);
            return c == jksd_pkg::CH_SPACE || c == jksd_pkg::CH_TAB ||
                   c == jksd_pkg::CH_CR || c == jksd_pkg::CH_LF ||
                   c == jksd_pkg::CH_COMMA || c == jksd_pkg::CH_COLON;
        endfunction

        function int nibble(logic [jksd_pkg::CHAR_W-1:0] c);
            if (c >= DIGIT_0 && c <= DIGIT_0 + 9)
                return int'(c - DIGIT_0);
            if (c >= LOWER_A && c <= LOWER_A + 5)
                return int'(c - LOWER_A) + 10;
            if (c >= UPPER_A && c <= UPPER_A + 5)
                return int'(c - UPPER_A) + 10;
            return -1;
        endfunction

        function void note_input(logic [jksd_pkg::CHAR_W-1:0] c, logic eoi);
            jksd_pkg::result_t           r;
            logic [jksd_pkg::CHAR_W-1:0] quote;
            int                          d;
            r = '0;
            if (mode == jksd_pkg::MODE_QUOTED) begin
                quote = single_quoted ? jksd_pkg::CH_SQUOTE : jksd_pkg::CH_DQUOTE;
                if (eoi) begin
                    r.failed = 1'b1;
                end
                else if (in_escape) begin
                    in_escape = 1'b0;
                    r.out_valid = 1'b1;
                    case (c)
                        jksd_pkg::CH_BACKSLASH, jksd_pkg::CH_DQUOTE,
                        jksd_pkg::CH_SLASH: r.out_char = c;
                        jksd_pkg::CH_LOWER_B: r.out_char = jksd_pkg::CH_BS;
                        jksd_pkg::CH_LOWER_T: r.out_char = jksd_pkg::CH_TAB;
                        jksd_pkg::CH_LOWER_N: r.out_char = jksd_pkg::CH_LF;
                        jksd_pkg::CH_LOWER_R: r.out_char = jksd_pkg::CH_CR;
                        jksd_pkg::CH_LOWER_F: r.out_char = jksd_pkg::CH_FF;
                        jksd_pkg::CH_LOWER_U:
                        begin
                            r.out_valid = 1'b0;
                            hex_value = '0;
                            hex_count = '0;
                        end
                        default:
                        begin
                            r.out_valid = 1'b0;
                            r.failed = 1'b1;
                        end
                    endcase
                end
                else if (c == quote) begin
                    r.finished = 1'b1;
                end
                else if (c == jksd_pkg::CH_BACKSLASH) begin
                    in_escape = 1'b1;
                end
                else if (hex_count < jksd_pkg::HEX_IDLE) begin
                    d = nibble(c);
                    if (d < 0) begin
                        r.failed = 1'b1;
                    end
                    else begin
                        hex_value = {hex_value[jksd_pkg::HEX_W-5:0], 4'(d)};
                        hex_count = hex_count + 1'b1;
                        if (hex_count == jksd_pkg::HEX_IDLE) begin
                            r.out_valid = 1'b1;
                            r.out_char = jksd_pkg::CHAR_W'(hex_value);
                        end
                    end
                end
                else begin
                    r.out_valid = 1'b1;
                    r.out_char = c;
                end
            end
            else if (mode == jksd_pkg::MODE_BARE) begin
                if (eoi) begin
                    r.finished = 1'b1;
                end
                else if (ends_symbol(c)) begin
                    r.finished = 1'b1;
                    r.pushed_back = 1'b1;
                end
                else begin
                    r.out_valid = 1'b1;
                    r.out_char = c;
                end
            end
            else begin
                if (eoi) begin
                    r.failed = 1'b1;
                end
                else if (c == jksd_pkg::CH_DQUOTE || c == jksd_pkg::CH_SQUOTE) begin
                    clear_token();
                    mode = jksd_pkg::MODE_QUOTED;
                    single_quoted = (c == jksd_pkg::CH_SQUOTE);
                end
                else begin
                    clear_token();
                    mode = jksd_pkg::MODE_BARE;
                    r.out_valid = 1'b1;
                    r.out_char = c;
                end
            end
            if (r.finished || r.failed)
                clear_token();
            pending_results.push_back(r);
        endfunction

        function void compare_field(string name, int unsigned want, int unsigned got);
            if (want != got) begin
                errors++;
                $display("%0t: %s expected %0h, got %0h", $time, name, want, got);
            end
        endfunction

        function void check_result(logic [23:0] data, logic last, logic [2:0] user);
            jksd_pkg::result_t want;
            if (pending_results.size() == 0) begin
                errors++;
                $display("%0t: unexpected result, expected none, got tdata %0h tlast %0b tuser %0b",
                         $time, data, last, user);
                return;
            end
            want = pending_results.pop_front();
            compare_field("out_valid", want.out_valid, user[0]);
            compare_field("out_char", want.out_char, data[jksd_pkg::CHAR_W-1:0]);
            compare_field("tdata padding", 0, data[23:jksd_pkg::CHAR_W]);
            compare_field("finished", want.finished, last);
            compare_field("failed", want.failed, user[1]);
            compare_field("pushed_back", want.pushed_back, user[2]);
        endfunction

        function int pending();
            return pending_results.size();
        endfunction
    endclass

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [23:0] s_axis_tdata = '0;
    logic        s_axis_tlast = 1'b0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [23:0] m_axis_tdata;
    logic        m_axis_tlast;
    logic [2:0]  m_axis_tuser;

    decoder_scoreboard sb = new();
    bit calm = 1'b0;
    bit hold_request = 1'b0;
    int sent = 0;
    int idle_cycles = 0;

    json_key_string_decoder dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tuser  (m_axis_tuser)
    );

    always #5 clk = ~clk;

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (calm || r < 60)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    function automatic logic [jksd_pkg::CHAR_W-1:0] any_char();
        int r;
        r = $urandom_range(0, 9);
        if (r < 5)
            return jksd_pkg::CHAR_W'($urandom_range(32, 126));
        if (r < 7)
            return jksd_pkg::CHAR_W'($urandom_range(0, 31));
        if (r < 9)
            return jksd_pkg::CHAR_W'($urandom_range(0, MAX_CP));
        return jksd_pkg::CHAR_W'($urandom_range(21'h100000, MAX_CP));
    endfunction

    function automatic logic [jksd_pkg::CHAR_W-1:0] hex_char(int v);
        if (v < 10)
            return DIGIT_0 + jksd_pkg::CHAR_W'(v);
        return ($urandom_range(0, 1) ? UPPER_A : LOWER_A) + jksd_pkg::CHAR_W'(v - 10);
    endfunction

    task automatic send_item(input logic [jksd_pkg::CHAR_W-1:0] c, input logic eoi);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {3'b000, c};
        s_axis_tlast <= eoi;
        do
            @(posedge clk);
        while (!s_axis_tready);
        sb.note_input(c, eoi);
        sent++;
    endtask

    task automatic send_escape(input logic [jksd_pkg::CHAR_W-1:0] c);
        send_item(jksd_pkg::CH_BACKSLASH, 1'b0);
        send_item(c, 1'b0);
    endtask

    task automatic random_token();
        int                          kind;
        int                          len;
        int                          n;
        logic [jksd_pkg::CHAR_W-1:0] q;
        logic [jksd_pkg::CHAR_W-1:0] c;
        kind = $urandom_range(0, 99);
        if (kind < 65) begin
            q = $urandom_range(0, 1) ? jksd_pkg::CH_SQUOTE : jksd_pkg::CH_DQUOTE;
            send_item(q, 1'b0);
            len = $urandom_range(0, 8);
            for (int i = 0; i < len; i++) begin
                n = $urandom_range(0, 9);
                if (n < 5) begin
                    do
                        c = any_char();
                    while (c == q || c == jksd_pkg::CH_BACKSLASH);
                    send_item(c, 1'b0);
                end
                else if (n < 8) begin
                    send_escape(ESCAPES[$urandom_range(0, 7)]);
                end
                else begin
                    send_escape(jksd_pkg::CH_LOWER_U);
                    for (int j = 0; j < 4; j++) begin
                        if ($urandom_range(0, 9) == 0)
                            send_escape(ESCAPES[$urandom_range(0, 7)]);
                        send_item(hex_char($urandom_range(0, 15)), 1'b0);
                    end
                end
            end
            n = $urandom_range(0, 11);
            case (n)
                0: send_item(any_char(), 1'b1);
                1: send_escape($urandom_range(0, 1) ? jksd_pkg::CH_SQUOTE : LOWER_X);
                2:
                begin
                    send_escape(jksd_pkg::CH_LOWER_U);
                    send_item(hex_char($urandom_range(0, 15)), 1'b0);
                    send_item($urandom_range(0, 1) ? LOWER_G : any_char(), 1'b0);
                end
                3:
                begin
                    send_escape(jksd_pkg::CH_LOWER_U);
                    send_item(hex_char($urandom_range(0, 15)), 1'b0);
                    send_item(q, 1'b0);
                end
                default: send_item(q, 1'b0);
            endcase
        end
        else if (kind < 90) begin
            do
                c = any_char();
            while (c == jksd_pkg::CH_SQUOTE || c == jksd_pkg::CH_DQUOTE);
            send_item(c, 1'b0);
            len = $urandom_range(0, 6);
            for (int i = 0; i < len; i++) begin
                do
                    c = any_char();
                while (sb.ends_symbol(c));
                send_item(c, 1'b0);
            end
            if ($urandom_range(0, 3) == 0)
                send_item(any_char(), 1'b1);
            else
                send_item(SYMBOL_ENDS[$urandom_range(0, 5)], 1'b0);
        end
        else begin
            len = $urandom_range(1, 4);
            for (int i = 0; i < len; i++)
                send_item(any_char(), $urandom_range(0, 3) == 0);
        end
    endtask

    initial begin
        int hold_left;
        int stall_left;
        hold_left = 0;
        stall_left = 0;
        forever begin
            @(posedge clk);
            if (m_axis_tvalid && m_axis_tready)
                sb.check_result(m_axis_tdata, m_axis_tlast, m_axis_tuser);
            if (hold_request) begin
                hold_left = HOLD_CYCLES;
                hold_request = 1'b0;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_axis_tready <= 1'b0;
            end
            else if (stall_left > 0) begin
                stall_left--;
                m_axis_tready <= 1'b0;
            end
            else begin
                m_axis_tready <= rst_n;
                if (!calm && $urandom_range(0, 3) == 0)
                    stall_left = pick_gap();
            end
        end
    end

    always @(posedge clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    initial begin
        int  tokens;
        bit  pressed;
        tokens = 0;
        pressed = 1'b0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // End of input before any token, then bare symbols, the first led by a terminator.
        send_item(MAX_CP, 1'b1);
        send_item(jksd_pkg::CH_COLON, 1'b0);
        send_item(jksd_pkg::CH_TAB, 1'b0);
        send_item(MAX_CP, 1'b0);
        send_item(21'h1FFFFF, 1'b0);
        send_item(21'h0, 1'b1);
        // A single quote right after a backslash is a bad escape.
        send_item(jksd_pkg::CH_SQUOTE, 1'b0);
        send_escape(jksd_pkg::CH_SQUOTE);
        // A backslash escape in the middle of a hex run, then the run completes.
        send_item(jksd_pkg::CH_DQUOTE, 1'b0);
        send_escape(jksd_pkg::CH_LOWER_U);
        send_item(UPPER_A + 21'd5, 1'b0);
        send_escape(jksd_pkg::CH_LOWER_N);
        send_item(LOWER_A + 21'd5, 1'b0);
        send_item(UPPER_A + 21'd5, 1'b0);
        send_item(DIGIT_0 + 21'd9, 1'b0);
        send_item(jksd_pkg::CH_SQUOTE, 1'b0);
        // The closing quote ends the token in the middle of a hex run.
        send_escape(jksd_pkg::CH_LOWER_U);
        send_item(DIGIT_0, 1'b0);
        send_item(jksd_pkg::CH_DQUOTE, 1'b0);
        // End of input inside a quoted token, and a bad hex digit.
        send_item(jksd_pkg::CH_DQUOTE, 1'b0);
        send_item(21'h0, 1'b1);
        send_item(jksd_pkg::CH_DQUOTE, 1'b0);
        send_escape(jksd_pkg::CH_LOWER_U);
        send_item(LOWER_G, 1'b0);

        while (sent < ITEM_TARGET) begin
            if (tokens % 40 == 0)
                calm = ($urandom_range(0, 3) == 0);
            if (!pressed && sent > ITEM_TARGET / 2) begin
                hold_request = 1'b1;
                pressed = 1'b1;
            end
            random_token();
            tokens++;
        end
        s_axis_tvalid <= 1'b0;

        while (sb.pending() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (sb.errors == 0 && sb.pending() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
